>>> sv/vls_pkg.sv
// Shared types and constants of the value list with sort unit.
package vls_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND   = 3'd0,
        KIND_DEL_AT   = 3'd1,
        KIND_DEL_TAIL = 3'd2,
        KIND_SORT     = 3'd3,
        KIND_READ     = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 3'd0,
        STATUS_EMPTY  = 3'd1,
        STATUS_RANGE  = 3'd2,
        STATUS_FULL   = 3'd3,
        STATUS_NOSORT = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_SHIFT,
        CELL_SORT
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cell_op           op;
        logic [IDX_W-1:0]   del_pos;
        logic [IDX_W-1:0]   rd_pos;
        logic [CNT_W-1:0]   count;
        logic               phase;
        logic [VALUE_W-1:0] value;
    } t_cell_cmd;

endpackage

>>> sv/vls_cell.sv
// One list cell: holds one entry, shifts, swaps with its neighbours and relays reads.
module vls_cell import vls_pkg::*; (
    input  logic               i_clk,
    input  logic [IDX_W-1:0]   i_pos,
    input  t_cell_cmd          i_cmd,
    input  logic [VALUE_W-1:0] i_left_val,
    input  logic [VALUE_W-1:0] i_right_val,
    input  logic [VALUE_W-1:0] i_right_tap,
    output logic [VALUE_W-1:0] o_val,
    output logic [VALUE_W-1:0] o_tap
);

    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] n_val;
    logic [VALUE_W-1:0] r_tap;
    logic [VALUE_W-1:0] n_tap;
    logic [CNT_W-1:0]   w_pos_ext;
    logic               w_lower_act;
    logic               w_upper_act;

    assign w_pos_ext   = CNT_W'(i_pos);
    assign w_lower_act = (i_pos[0] == i_cmd.phase) && ((w_pos_ext + 1'b1) < i_cmd.count);
    assign w_upper_act = (i_pos[0] != i_cmd.phase) && (i_pos != '0)
                         && (w_pos_ext < i_cmd.count);

    always_comb begin
        n_val = r_val;
        case (i_cmd.op)
            CELL_APPEND: begin
                if (w_pos_ext == i_cmd.count) begin
                    n_val = i_cmd.value;
                end
            end
            CELL_SHIFT: begin
                if (i_pos >= i_cmd.del_pos) begin
                    n_val = i_right_val;
                end
            end
            CELL_SORT: begin
                if (w_lower_act && (i_right_val < r_val)) begin
                    n_val = i_right_val;
                end else if (w_upper_act && (r_val < i_left_val)) begin
                    n_val = i_left_val;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    assign n_tap = (i_pos == i_cmd.rd_pos) ? r_val : i_right_tap;

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_tap <= n_tap;
    end

    assign o_val = r_val;
    assign o_tap = r_tap;

endmodule

>>> sv/value_list_with_sort_unit.sv
// Top level of the value list with sort unit: control, register port and cell row.
// Append, delete-at, delete-tail, refused and unused commands: result registered in the
// cycle after the input transaction; next transaction taken in the following cycle if the output is free.
// Successful sort and read-at: the cell row works in ST_RUN (odd-even passes, or the
// read relay walking down to cell 0), then ST_DONE registers the result once the output is free.
// Reset clears count, control and the output valid flag and sets sortable; entries are not cleared.
module value_list_with_sort_unit import vls_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,   // value[31:0], index[37:32], zero pad
    input  logic [KIND_W-1:0]   s_tuser,   // kind[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // read_value[31:0], entry_count[38:32], zero pad
    output logic [STATUS_W-1:0] m_tuser,   // status[2:0]
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    t_state             r_state;
    t_state             n_state;
    logic               r_sortable;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [IDX_W-1:0]   r_cnt;
    t_kind              r_kind;
    logic [INDEX_W-1:0] r_idx;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [VALUE_W-1:0] r_out_value;
    logic [CNT_W-1:0]   r_out_count;

    t_kind              w_kind;
    logic [VALUE_W-1:0] w_value;
    logic [INDEX_W-1:0] w_index;
    logic [CNT_W-1:0]   w_index_ext;
    t_status            w_status;
    logic               w_multi;
    logic               w_accept;
    logic               w_out_free;
    logic               w_run_last;
    logic               w_load;
    t_status            w_load_status;
    logic [VALUE_W-1:0] w_load_value;
    t_cell_cmd          w_cmd;

    logic [VALUE_W-1:0] w_val [CAPACITY];
    logic [VALUE_W-1:0] w_tap [CAPACITY];

    assign w_kind      = t_kind'(s_tuser);
    assign w_value     = s_tdata[VALUE_W-1:0];
    assign w_index     = s_tdata[VALUE_W+INDEX_W-1:VALUE_W];
    assign w_index_ext = CNT_W'(w_index);
    assign w_accept    = s_tvalid && s_tready;
    assign w_out_free  = !r_out_valid || m_tready;
    assign w_run_last  = (r_cnt == IDX_W'(CAPACITY - 1));

    always_comb begin
        w_status = STATUS_OK;
        case (w_kind)
            KIND_APPEND: begin
                if (r_count >= CNT_W'(CAPACITY)) begin
                    w_status = STATUS_FULL;
                end
            end
            KIND_DEL_AT, KIND_READ: begin
                if (r_count == '0) begin
                    w_status = STATUS_EMPTY;
                end else if (w_index_ext >= r_count) begin
                    w_status = STATUS_RANGE;
                end
            end
            KIND_DEL_TAIL: begin
                if (r_count == '0) begin
                    w_status = STATUS_EMPTY;
                end
            end
            KIND_SORT: begin
                if (!r_sortable) begin
                    w_status = STATUS_NOSORT;
                end else if (r_count == '0) begin
                    w_status = STATUS_EMPTY;
                end
            end
            default: begin
                w_status = STATUS_OK;
            end
        endcase
    end

    assign w_multi = (w_status == STATUS_OK)
                     && ((w_kind == KIND_SORT) || (w_kind == KIND_READ));

    always_comb begin
        n_count = r_count;
        if (w_accept && (w_status == STATUS_OK)) begin
            case (w_kind)
                KIND_APPEND:                n_count = r_count + 1'b1;
                KIND_DEL_AT, KIND_DEL_TAIL: n_count = r_count - 1'b1;
                default:                    n_count = r_count;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_multi) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_run_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_tready      = 1'b0;
        w_load        = 1'b0;
        w_load_status = w_status;
        w_load_value  = '0;
        w_cmd.op      = CELL_HOLD;
        w_cmd.del_pos = IDX_W'(w_index);
        w_cmd.rd_pos  = IDX_W'(r_idx);
        w_cmd.count   = r_count;
        w_cmd.phase   = r_cnt[0];
        w_cmd.value   = w_value;
        case (r_state)
            ST_IDLE: begin
                s_tready = w_out_free;
                if (w_accept && !w_multi) begin
                    w_load = 1'b1;
                    if (w_status == STATUS_OK) begin
                        case (w_kind)
                            KIND_APPEND: w_cmd.op = CELL_APPEND;
                            KIND_DEL_AT: w_cmd.op = CELL_SHIFT;
                            default:     w_cmd.op = CELL_HOLD;
                        endcase
                    end
                end
            end
            ST_RUN: begin
                if (r_kind == KIND_SORT) begin
                    w_cmd.op = CELL_SORT;
                end
            end
            ST_DONE: begin
                w_load        = w_out_free;
                w_load_status = STATUS_OK;
                w_load_value  = (r_kind == KIND_READ) ? w_tap[0] : '0;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sortable  <= 1'b1;
            r_count     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
                r_sortable <= pwdata[0];
            end
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= w_kind;
            r_idx  <= w_index;
        end
        if (w_load) begin
            r_out_status <= w_load_status;
            r_out_value  <= w_load_value;
            r_out_count  <= n_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] w_left;
        logic [VALUE_W-1:0] w_right;
        logic [VALUE_W-1:0] w_right_tap;

        if (g == 0) begin : g_first
            assign w_left = w_val[g];
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right     = w_val[g];
            assign w_right_tap = '0;
        end else begin : g_mid_r
            assign w_right     = w_val[g+1];
            assign w_right_tap = w_tap[g+1];
        end

        vls_cell u_cell (
            .i_clk       (i_clk),
            .i_pos       (IDX_W'(g)),
            .i_cmd       (w_cmd),
            .i_left_val  (w_left),
            .i_right_val (w_right),
            .i_right_tap (w_right_tap),
            .o_val       (w_val[g]),
            .o_tap       (w_tap[g])
        );
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_status;
    assign m_tdata  = {1'b0, r_out_count, r_out_value};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {31'd0, r_sortable} : 32'd0;

endmodule

>>> sv/vls_checker.sv
// Port-level checks of the value list with sort unit, bound to the top level.
module vls_checker import vls_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [39:0]         m_tdata,
    input logic [STATUS_W-1:0] m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transaction");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser <= STATUS_W'(STATUS_NOSORT)))
        else $error("status code out of range");

    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != STATUS_W'(STATUS_OK)) |-> (m_tdata[VALUE_W-1:0] == '0))
        else $error("read value on a failed command");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[VALUE_W+CNT_W-1:VALUE_W] <= CNT_W'(CAPACITY)))
        else $error("entry count above capacity");

endmodule

bind value_list_with_sort_unit vls_checker u_vls_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
